/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/mdel_pkg.sv */
// shared types and constants for the multichannel debounce core
// no dependencies
`timescale 1ns / 1ps

package mdel_pkg;

   // field widths
   localparam int LEVEL_WIDTH     = 32;
   localparam int FILTER_WIDTH    = 8;
   localparam int ACTIVE_WIDTH    = 6;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 8;

   // default channel count
   localparam int CHANNELS_DEFAULT = 32;

   // register reset values
   localparam logic [FILTER_WIDTH-1:0] FILTER_TIME_RESET     = 8'd10;
   localparam logic [ACTIVE_WIDTH-1:0] ACTIVE_CHANNELS_RESET = 6'd13;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_TIME     = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACTIVE_CHANNELS = 1'd1;

   // per-lane control for one word
   typedef struct packed {
      logic step;
      logic level;
      logic clr_rise;
      logic clr_fall;
   } lane_ctl_type;

   // per-lane status after the sample, before the clears
   typedef struct packed {
      logic stable;
      logic rise;
      logic fall;
   } lane_stat_type;

   // one result word
   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] stable_levels;
      logic [LEVEL_WIDTH-1:0] rising_flags;
      logic [LEVEL_WIDTH-1:0] falling_flags;
   } rsp_word_type;

endpackage

/* rtl/mdel_lane.sv */
// one debounce channel: disagree counter, stable bit, sticky edge flags
// depends on mdel_pkg
`timescale 1ns / 1ps

module mdel_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mdel_pkg::lane_ctl_type               ctl,
   input  logic [mdel_pkg::FILTER_WIDTH-1:0]    filter_time,
   output mdel_pkg::lane_stat_type              stat
);
   import mdel_pkg::*;

   logic [FILTER_WIDTH-1:0] count_ff, count_in;
   logic                    stable_ff, stable_in;
   logic                    rise_ff, rise_in;
   logic                    fall_ff, fall_in;

   logic                    disagree;
   logic [FILTER_WIDTH:0]   count_inc;
   logic                    flip;

   // threshold test on the incremented count
   always_comb begin
      disagree  = ctl.level != stable_ff;
      count_inc = {1'b0, count_ff} + {{FILTER_WIDTH{1'b0}}, 1'b1};
      flip      = ctl.step && disagree && (count_inc >= {1'b0, filter_time});
   end

   // next state and reported status
   always_comb begin
      count_in = count_ff;
      if (ctl.step) begin
         if (!disagree || flip) begin
            count_in = '0;
         end else begin
            count_in = count_inc[FILTER_WIDTH-1:0];
         end
      end
      stable_in   = stable_ff ^ flip;
      stat.stable = stable_in;
      stat.rise   = rise_ff | (flip & ctl.level);
      stat.fall   = fall_ff | (flip & ~ctl.level);
      rise_in     = stat.rise & ~ctl.clr_rise;
      fall_in     = stat.fall & ~ctl.clr_fall;
   end

   // lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         stable_ff <= 1'b0;
         rise_ff   <= 1'b0;
         fall_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         stable_ff <= stable_in;
         rise_ff   <= rise_in;
         fall_ff   <= fall_in;
      end
   end

endmodule

/* rtl/mdel_rsp_buf.sv */
// two-entry result buffer: output register plus skid register
// depends on mdel_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mdel_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mdel_pkg::rsp_word_type push_word,
   output logic                   full,
   output logic                   out_valid,
   input  logic                   out_stall,
   output mdel_pkg::rsp_word_type out_word
);
   import mdel_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   rsp_word_type skid_word_ff, skid_word_in;
   logic         pop;

   // fill and drain
   always_comb begin
      pop           = out_valid_ff && !out_stall;
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || pop) begin
         out_valid_in  = skid_valid_ff || push;
         out_word_in   = skid_valid_ff ? skid_word_ff : push_word;
         skid_valid_in = skid_valid_ff && push;
         if (push) begin
            skid_word_in = push_word;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_word_in  = push_word;
      end
   end

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

   // checks
   `ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `ASSERT_IMPLY(a_no_push_when_full, clock, reset, push, !skid_valid_ff)
   `ASSERT_NEXT(a_held_push_to_skid, clock, reset, push && out_valid_ff && out_stall,
      skid_valid_ff)

endmodule

/* rtl/multichannel_debounce_edge_latch_core.sv */
// top level of the multichannel debounce core with sticky edge flags
// depends on mdel_pkg, mdel_lane and mdel_rsp_buf
`timescale 1ns / 1ps

// Debounces up to CHANNELS level inputs, one sample word per cycle while
// req_stall is low. Each channel flips its stable level after filter_time
// consecutive disagreeing samples and latches a sticky rising or falling
// flag; each word returns the stable levels and flags after its sample, then
// clears the flags named in its clear masks. Every lane updates its counter
// and flags combinationally from its registered state, and the result enters
// a two-entry result buffer that keeps the input taking words while one
// result waits. Channels at or above active_channels are frozen but their
// flags still clear; output bits at or above CHANNELS read as zero.
// Configuration is written with csr_write_enable while the core is idle.

module multichannel_debounce_edge_latch_core #(
   parameter int CHANNELS = mdel_pkg::CHANNELS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_write_enable,
   input  logic [mdel_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mdel_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   // sample words
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_sample_valid,
   input  logic [mdel_pkg::LEVEL_WIDTH-1:0]      req_raw_levels,
   input  logic [mdel_pkg::LEVEL_WIDTH-1:0]      req_clear_rising_mask,
   input  logic [mdel_pkg::LEVEL_WIDTH-1:0]      req_clear_falling_mask,
   // result words
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mdel_pkg::LEVEL_WIDTH-1:0]      rsp_stable_levels,
   output logic [mdel_pkg::LEVEL_WIDTH-1:0]      rsp_rising_flags,
   output logic [mdel_pkg::LEVEL_WIDTH-1:0]      rsp_falling_flags
);
   import mdel_pkg::*;

   logic [FILTER_WIDTH-1:0] filter_time_ff, filter_time_in;
   logic [ACTIVE_WIDTH-1:0] active_channels_ff, active_channels_in;

   logic          accept;
   logic          buf_full;
   rsp_word_type  push_word;
   rsp_word_type  out_word;

   // register decode
   always_comb begin
      filter_time_in     = filter_time_ff;
      active_channels_in = active_channels_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FILTER_TIME: begin
               filter_time_in = csr_write_data[FILTER_WIDTH-1:0];
            end
            CSR_ACTIVE_CHANNELS: begin
               active_channels_in = csr_write_data[ACTIVE_WIDTH-1:0];
            end
            default: begin
               filter_time_in = filter_time_ff;
            end
         endcase
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_time_ff     <= FILTER_TIME_RESET;
         active_channels_ff <= ACTIVE_CHANNELS_RESET;
      end else begin
         filter_time_ff     <= filter_time_in;
         active_channels_ff <= active_channels_in;
      end
   end

   // input handshake
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   // debounce lanes, unused high bits read as zero
   for (genvar i = 0; i < LEVEL_WIDTH; i++) begin : g_bit
      if (i < CHANNELS) begin : g_lane
         lane_ctl_type  ctl;
         lane_stat_type stat;

         always_comb begin
            ctl.step     = accept && req_sample_valid
                           && (ACTIVE_WIDTH'(i) < active_channels_ff);
            ctl.level    = req_raw_levels[i];
            ctl.clr_rise = accept && req_clear_rising_mask[i];
            ctl.clr_fall = accept && req_clear_falling_mask[i];
         end

         mdel_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .filter_time (filter_time_ff),
            .stat        (stat)
         );

         assign push_word.stable_levels[i] = stat.stable;
         assign push_word.rising_flags[i]  = stat.rise;
         assign push_word.falling_flags[i] = stat.fall;
      end else begin : g_pad
         assign push_word.stable_levels[i] = 1'b0;
         assign push_word.rising_flags[i]  = 1'b0;
         assign push_word.falling_flags[i] = 1'b0;
      end
   end

   // result buffer
   mdel_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_word (push_word),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   assign rsp_stable_levels = out_word.stable_levels;
   assign rsp_rising_flags  = out_word.rising_flags;
   assign rsp_falling_flags = out_word.falling_flags;

endmodule

/* bench/testbench.sv */
// self-checking bench for the multichannel debounce core with sticky edge flags
// depends on mdel_pkg and multichannel_debounce_edge_latch_core; reads no files
`timescale 1ns / 1ps

module testbench;
   import mdel_pkg::*;

   localparam int LANES = CHANNELS_DEFAULT;

   // tracks debounce state and flags, holds the words the core should return
   class level_flag_tracker;
      logic [FILTER_WIDTH-1:0] filter_time;
      logic [ACTIVE_WIDTH-1:0] active_count;
      logic [LEVEL_WIDTH-1:0]  stable_bits;
      logic [LEVEL_WIDTH-1:0]  rise_hold;
      logic [LEVEL_WIDTH-1:0]  fall_hold;
      logic [7:0]              disagree_run [LANES];
      rsp_word_type            expected_words [$];
      int                      mismatches;

      function new();
         filter_time  = FILTER_TIME_RESET;
         active_count = ACTIVE_CHANNELS_RESET;
         stable_bits  = '0;
         rise_hold    = '0;
         fall_hold    = '0;
         foreach (disagree_run[i]) disagree_run[i] = '0;
         mismatches   = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
         if (idx == CSR_FILTER_TIME) begin
            filter_time = data[FILTER_WIDTH-1:0];
         end else if (idx == CSR_ACTIVE_CHANNELS) begin
            active_count = data[ACTIVE_WIDTH-1:0];
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // apply one accepted word: debounce, record the result, then clear flags
      function void note_sample(logic sample_ok, logic [LEVEL_WIDTH-1:0] raw,
                                logic [LEVEL_WIDTH-1:0] clr_rise,
                                logic [LEVEL_WIDTH-1:0] clr_fall);
         int           lanes;
         int           run;
         int           i;
         rsp_word_type w;
         lanes = (active_count > LANES) ? LANES : active_count;
         if (sample_ok) begin
            for (i = 0; i < lanes; i++) begin
               if (raw[i] == stable_bits[i]) begin
                  disagree_run[i] = '0;
               end else begin
                  run = disagree_run[i] + 1;
                  if (run >= filter_time) begin
                     disagree_run[i] = '0;
                     stable_bits[i]  = raw[i];
                     if (raw[i]) rise_hold[i] = 1'b1;
                     else fall_hold[i] = 1'b1;
                  end else begin
                     disagree_run[i] = run[7:0];
                  end
               end
            end
         end
         w.stable_levels = stable_bits;
         w.rising_flags  = rise_hold;
         w.falling_flags = fall_hold;
         expected_words.push_back(w);
         rise_hold = rise_hold & ~clr_rise;
         fall_hold = fall_hold & ~clr_fall;
      endfunction

      task report(string msg);
         $display("%0t ns mismatch: %s", $time, msg);
         mismatches++;
      endtask

      // compare one returned word with the oldest expectation
      task check_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word stable=%h", got.stable_levels));
         end else begin
            want = expected_words.pop_front();
            if (got.stable_levels !== want.stable_levels)
               report($sformatf("stable_levels %h, want %h",
                                got.stable_levels, want.stable_levels));
            if (got.rising_flags !== want.rising_flags)
               report($sformatf("rising_flags %h, want %h",
                                got.rising_flags, want.rising_flags));
            if (got.falling_flags !== want.falling_flags)
               report($sformatf("falling_flags %h, want %h",
                                got.falling_flags, want.falling_flags));
         end
      endtask
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = CSR_FILTER_TIME;
   logic [CSR_DATA_WIDTH-1:0]   csr_write_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_sample_valid = 1'b0;
   logic [LEVEL_WIDTH-1:0]      req_raw_levels = '0;
   logic [LEVEL_WIDTH-1:0]      req_clear_rising_mask = '0;
   logic [LEVEL_WIDTH-1:0]      req_clear_falling_mask = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [LEVEL_WIDTH-1:0]      rsp_stable_levels;
   logic [LEVEL_WIDTH-1:0]      rsp_rising_flags;
   logic [LEVEL_WIDTH-1:0]      rsp_falling_flags;

   level_flag_tracker tracker = new();
   bit                calm = 1'b0;

   multichannel_debounce_edge_latch_core u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_sample_valid       (req_sample_valid),
      .req_raw_levels         (req_raw_levels),
      .req_clear_rising_mask  (req_clear_rising_mask),
      .req_clear_falling_mask (req_clear_falling_mask),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_stable_levels      (rsp_stable_levels),
      .rsp_rising_flags       (rsp_rising_flags),
      .rsp_falling_flags      (rsp_falling_flags)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // hang guard
   initial begin
      #4_000_000;
      $display("** multichannel_debounce_edge_latch_core: FAILED **");
      $finish;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [LEVEL_WIDTH-1:0] pick_mask();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return '0;
      if (r == 6) return '1;
      if (r < 9) return $urandom & $urandom;
      return $urandom;
   endfunction

   // result side back-pressure
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) stall_left--;
         else stall_left = pick_gap();
         rsp_stall <= (stall_left > 0);
      end
   end

   // result monitor: a word is taken at the edge after a low stall
   initial begin
      rsp_word_type got;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.stable_levels = rsp_stable_levels;
            got.rising_flags  = rsp_rising_flags;
            got.falling_flags = rsp_falling_flags;
            tracker.check_word(got);
         end
      end
   end

   // present one sample word and hold it until the core takes it
   task automatic send_word(input logic sample_ok, input logic [LEVEL_WIDTH-1:0] raw,
                            input logic [LEVEL_WIDTH-1:0] clr_rise,
                            input logic [LEVEL_WIDTH-1:0] clr_fall);
      int gap;
      bit taken;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_sample_valid       <= sample_ok;
      req_raw_levels         <= raw;
      req_clear_rising_mask  <= clr_rise;
      req_clear_falling_mask <= clr_fall;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = (req_stall === 1'b0);
         if (taken) tracker.note_sample(sample_ok, raw, clr_rise, clr_fall);
         @(posedge clock);
      end
   endtask

   // drain every outstanding word, then idle before returning
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_WIDTH-1:0] filt,
                                 input logic [CSR_DATA_WIDTH-1:0] act);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FILTER_TIME;
      csr_write_data   <= filt;
      @(posedge clock);
      csr_index        <= CSR_ACTIVE_CHANNELS;
      csr_write_data   <= act;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.write_reg(CSR_FILTER_TIME, filt);
      tracker.write_reg(CSR_ACTIVE_CHANNELS, act);
   endtask

   // random words around a slowly moving target level, runs sized to the filter
   task automatic run_phase(input int count, input int filt);
      logic [LEVEL_WIDTH-1:0] target;
      logic [LEVEL_WIDTH-1:0] raw;
      int                     eff;
      int                     run_left;
      int                     k;
      eff = (filt == 0) ? 1 : filt;
      target = $urandom;
      run_left = 0;
      for (k = 0; k < count; k++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(eff / 2 + 1, 2 * eff + 3);
            case ($urandom_range(0, 3))
               0: target = $urandom;
               1: target = target ^ ($urandom & $urandom);
               2: target = ~target;
               default: target = target ^ (32'h1 << $urandom_range(0, 31));
            endcase
         end
         run_left--;
         raw = target;
         if ($urandom_range(0, 3 + eff / 8) == 0) raw = raw ^ ($urandom & $urandom & $urandom);
         if ($urandom_range(0, 10 + eff) == 0) raw = $urandom;
         send_word($urandom_range(0, 9) != 0, raw, pick_mask(), pick_mask());
      end
   endtask

   initial begin
      int                      p;
      int                      total;
      int                      count;
      int                      r;
      int                      k;
      logic [CSR_DATA_WIDTH-1:0] filt;
      logic [CSR_DATA_WIDTH-1:0] act;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, no-sample word, full rise on the low 13 lanes
      send_word(1'b0, '1, '0, '0);
      for (k = 0; k < 10; k++) send_word(1'b1, '1, '0, '0);
      send_word(1'b1, '1, '1, '0);
      // partial falling run, then a lower filter time below the running count
      for (k = 0; k < 4; k++) send_word(1'b1, '0, '0, '0);
      apply_settings(8'd2, 8'd32);
      send_word(1'b1, '0, '0, '0);
      send_word(1'b1, 32'hAAAA_AAAA, '0, '0);
      send_word(1'b1, 32'hAAAA_AAAA, '0, '0);
      send_word(1'b1, 32'h5555_5555, 32'hFFFF_0000, '1);
      send_word(1'b0, '0, '0, '0);
      send_word(1'b1, 32'h5555_5555, '0, '0);
      send_word(1'b1, '1, '1, '1);

      // random phases over a spread of settings, extremes first
      total = 0;
      p = 0;
      while (total < 1800) begin
         case (p)
            0: begin filt = 8'd255; act = 8'd32; end
            1: begin filt = 8'd0;   act = 8'd63; end
            2: begin filt = 8'd1;   act = 8'd1;  end
            3: begin filt = 8'd3;   act = 8'd0;  end
            4: begin filt = 8'd6;   act = 8'd33; end
            default: begin
               r = $urandom_range(0, 9);
               if (r < 6) filt = CSR_DATA_WIDTH'($urandom_range(1, 12));
               else if (r < 8) filt = CSR_DATA_WIDTH'($urandom_range(13, 40));
               else if (r == 8) filt = CSR_DATA_WIDTH'($urandom_range(0, 1));
               else filt = CSR_DATA_WIDTH'($urandom_range(41, 100));
               r = $urandom_range(0, 3);
               if (r == 0) act = CSR_DATA_WIDTH'($urandom_range(0, 63));
               else if (r == 1) act = 8'd32;
               else act = CSR_DATA_WIDTH'($urandom_range(1, 31));
            end
         endcase
         count = (filt >= 40) ? 3 * int'(filt) + 60 : $urandom_range(60, 200);
         apply_settings(filt, act);
         calm = ($urandom_range(0, 3) == 0);
         run_phase(count, int'(filt));
         total += count;
         p++;
      end

      calm = 1'b0;
      settle();
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("** multichannel_debounce_edge_latch_core: PASSED **");
      end else begin
         $display("** multichannel_debounce_edge_latch_core: FAILED **");
      end
      $finish;
   end

endmodule

/* multichannel_debounce_edge_latch_core.f */
+incdir+rtl
rtl/mdel_pkg.sv
rtl/mdel_lane.sv
rtl/mdel_rsp_buf.sv
rtl/multichannel_debounce_edge_latch_core.sv
bench/testbench.sv
